/* rtl/g4o_pkg.sv */
package g4o_pkg;

  // Grid limits
  localparam int MAX_DIM   = 16;
  localparam int MAX_CELLS = 65536;

  // Field widths
  localparam int DIM_W   = 5;                      // size register width
  localparam int CRD_W   = 4;                      // in-grid coordinate width
  localparam int ICRD_W  = 6;                      // input coordinate width (signed)
  localparam int IDX_W   = $clog2(MAX_CELLS);      // linear index width
  localparam int CNT_W   = IDX_W + 1;              // wall count / cell total width
  localparam int ACT_W   = 2;
  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;

  // Bit memory organized as wide rows
  localparam int ROW_W      = 64;
  localparam int ROW_SEL_W  = $clog2(ROW_W);
  localparam int ROW_ADDR_W = IDX_W - ROW_SEL_W;
  localparam int MEM_ROWS   = MAX_CELLS / ROW_W;

  // Divider: one quotient bit per cycle
  localparam int DCNT_W = $clog2(IDX_W);

  // Action field bits
  localparam int ACT_WRITE_BIT = 0;
  localparam int ACT_INDEX_BIT = 1;

  // Register map (word index)
  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;
  localparam logic [1:0] REG_SIZE_W = 2'd3;

  // Axis select
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;
  localparam logic [1:0] AXIS_W = 2'd3;

  // Multiply-accumulate steps per access (z, y, x)
  localparam logic [1:0] MAC_LAST = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_DIV,
    ST_READ,
    ST_MOD
  } state_t;

  typedef enum logic {
    ALU_MAC,
    ALU_DIV
  } alu_op_t;

  // Request to the shared arithmetic unit
  typedef struct packed {
    alu_op_t          op;
    logic [CNT_W-1:0] a;    // accumulator, or dividend in the low bits
    logic [DIM_W-1:0] b;    // multiplier or divisor
    logic [DIM_W-1:0] c;    // addend, or partial remainder
  } alu_req_t;

  typedef struct packed {
    logic [CNT_W-1:0] res;  // a*b+c, or shifted dividend/quotient
    logic [DIM_W-1:0] rem;  // next partial remainder
  } alu_rsp_t;

  // Sizes above the maximum clamp to the maximum
  function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] s);
    return s[DIM_W-1] ? DIM_W'(MAX_DIM) : {1'b0, s[DIM_W-2:0]};
  endfunction

endpackage

/* rtl/g4o_alu.sv */
module g4o_alu (
  input  g4o_pkg::alu_req_t req,
  output g4o_pkg::alu_rsp_t rsp
);
  import g4o_pkg::*;

  logic [CNT_W+DIM_W-1:0] prod;
  logic [DIM_W-1:0]       trial;
  logic                   ge;

  // Multiply-add, or one restoring divide step
  always_comb begin
    prod  = (CNT_W+DIM_W)'(req.a) * (CNT_W+DIM_W)'(req.b);
    trial = {req.c[DIM_W-2:0], req.a[IDX_W-1]};
    ge    = (trial >= req.b);
    rsp   = '0;
    case (req.op)
      ALU_MAC: begin
        rsp.res = prod[CNT_W-1:0] + CNT_W'(req.c);
      end
      ALU_DIV: begin
        rsp.res = {1'b0, req.a[IDX_W-2:0], ge};
        rsp.rem = ge ? (trial - req.b) : trial;
      end
      default: rsp = '0;
    endcase
  end

endmodule

/* rtl/grid_4d_occupancy_store_top.sv */
// Paths: coordinate in grid runs ST_MAC, ST_READ, ST_MOD; coordinate outside the grid is
//   answered from ST_IDLE; index outside the grid, from ST_MAC; index in grid runs ST_MAC,
//   ST_DIV, ST_READ, ST_MOD (3 multiply-add steps, 3 x 16 divide steps). One item at a
//   time through the shared unit; busy falls with the result strobe; results cannot stall.
// Reset and every size write start a clearing pass over all 1024 rows (one 64-bit
//   row per cycle) during which busy is high; sizes reset to 16, wall count to 0.
module grid_4d_occupancy_store_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // item channel
  input  logic                               start,
  output logic                               busy,
  input  logic [g4o_pkg::ACT_W-1:0]          in_action,
  input  logic signed [g4o_pkg::ICRD_W-1:0]  in_coord_x,
  input  logic signed [g4o_pkg::ICRD_W-1:0]  in_coord_y,
  input  logic signed [g4o_pkg::ICRD_W-1:0]  in_coord_z,
  input  logic signed [g4o_pkg::ICRD_W-1:0]  in_coord_w,
  input  logic signed [g4o_pkg::CNT_W-1:0]   in_cell_index,
  input  logic                               in_write_value,
  // result channel
  output logic                               out_valid,
  output logic                               out_cell_value,
  output logic                               out_in_range,
  output logic [g4o_pkg::IDX_W-1:0]          out_linear_index,
  output logic [g4o_pkg::CRD_W-1:0]          out_out_x,
  output logic [g4o_pkg::CRD_W-1:0]          out_out_y,
  output logic [g4o_pkg::CRD_W-1:0]          out_out_z,
  output logic [g4o_pkg::CRD_W-1:0]          out_out_w,
  output logic [g4o_pkg::CNT_W-1:0]          out_wall_count,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [g4o_pkg::APB_AW-1:0]         paddr,
  input  logic [g4o_pkg::APB_DW-1:0]         pwdata,
  output logic [g4o_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);
  import g4o_pkg::*;

  state_t state_r, state_nxt;

  logic [DIM_W-1:0] size_x_r, size_y_r, size_z_r, size_w_r;
  logic [DIM_W-1:0] sx, sy, sz, sw;

  logic [ROW_ADDR_W-1:0] clr_row_r, clr_row_nxt;
  logic [ACT_W-1:0]      act_r, act_nxt;
  logic                  wv_r, wv_nxt;
  logic [CRD_W-1:0]      crd_x_r, crd_y_r, crd_z_r, crd_w_r;
  logic [CRD_W-1:0]      crd_x_nxt, crd_y_nxt, crd_z_nxt, crd_w_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  neg_r, neg_nxt;
  logic [CNT_W-1:0]      acc_r, acc_nxt;
  logic [1:0]            mstep_r, mstep_nxt;
  logic [IDX_W-1:0]      dvd_r, dvd_nxt;
  logic [DIM_W-1:0]      rem_r, rem_nxt;
  logic [DCNT_W-1:0]     dcnt_r, dcnt_nxt;
  logic [1:0]            axis_r, axis_nxt;
  logic [CNT_W-1:0]      wall_r, wall_nxt;
  logic [ROW_W-1:0]      rd_row_r;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_val_r, out_val_nxt;
  logic                  out_rng_r, out_rng_nxt;
  logic [IDX_W-1:0]      out_idx_r, out_idx_nxt;
  logic [CRD_W-1:0]      out_x_r, out_y_r, out_z_r, out_w_r;
  logic [CRD_W-1:0]      out_x_nxt, out_y_nxt, out_z_nxt, out_w_nxt;
  logic [CNT_W-1:0]      out_wall_r, out_wall_nxt;

  logic                  cfg_wr;
  logic                  accept;
  logic                  by_index, is_write;
  logic                  crd_ok;
  logic                  idx_ok;
  logic [1:0]            alu_axis;
  logic [DIM_W-1:0]      axis_size;
  logic [CRD_W-1:0]      axis_crd;
  logic                  old_bit;
  logic                  new_bit;

  logic                  mem_we;
  logic [ROW_ADDR_W-1:0] mem_waddr;
  logic [ROW_W-1:0]      mem_wdata;
  logic                  mem_re;
  logic [ROW_W-1:0]      cell_mem [MEM_ROWS];

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= DIM_W'(MAX_DIM);
      size_y_r <= DIM_W'(MAX_DIM);
      size_z_r <= DIM_W'(MAX_DIM);
      size_w_r <= DIM_W'(MAX_DIM);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SIZE_X: size_x_r <= pwdata[DIM_W-1:0];
        REG_SIZE_Y: size_y_r <= pwdata[DIM_W-1:0];
        REG_SIZE_Z: size_z_r <= pwdata[DIM_W-1:0];
        REG_SIZE_W: size_w_r <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SIZE_X: prdata = APB_DW'(size_x_r);
      REG_SIZE_Y: prdata = APB_DW'(size_y_r);
      REG_SIZE_Z: prdata = APB_DW'(size_z_r);
      REG_SIZE_W: prdata = APB_DW'(size_w_r);
      default:    prdata = '0;
    endcase
  end

  assign sx = eff_size(size_x_r);
  assign sy = eff_size(size_y_r);
  assign sz = eff_size(size_z_r);
  assign sw = eff_size(size_w_r);

  // Handshake and decode
  assign busy     = (state_r != ST_IDLE);
  assign accept   = start & ~busy;
  assign by_index = act_r[ACT_INDEX_BIT];
  assign is_write = act_r[ACT_WRITE_BIT];

  // Coordinate range check on the incoming item
  assign crd_ok = ~in_coord_x[ICRD_W-1] & (in_coord_x[DIM_W-1:0] < sx) &
                  ~in_coord_y[ICRD_W-1] & (in_coord_y[DIM_W-1:0] < sy) &
                  ~in_coord_z[ICRD_W-1] & (in_coord_z[DIM_W-1:0] < sz) &
                  ~in_coord_w[ICRD_W-1] & (in_coord_w[DIM_W-1:0] < sw);

  // Axis feeding the shared unit: z, y, x for multiply-add; x, y, z for divide
  assign alu_axis = (state_r == ST_DIV) ? axis_r : (AXIS_Z - mstep_r);

  always_comb begin
    case (alu_axis)
      AXIS_X:  begin axis_size = sx; axis_crd = crd_x_r; end
      AXIS_Y:  begin axis_size = sy; axis_crd = crd_y_r; end
      AXIS_Z:  begin axis_size = sz; axis_crd = crd_z_r; end
      default: begin axis_size = sw; axis_crd = crd_w_r; end
    endcase
  end

  always_comb begin
    alu_req.b = axis_size;
    if (state_r == ST_DIV) begin
      alu_req.op = ALU_DIV;
      alu_req.a  = CNT_W'(dvd_r);
      alu_req.c  = rem_r;
    end else begin
      alu_req.op = ALU_MAC;
      alu_req.a  = acc_r;
      alu_req.c  = by_index ? '0 : DIM_W'(axis_crd);
    end
  end

  g4o_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Index bound check against the cell total from the last multiply step
  assign idx_ok  = ~neg_r & ({1'b0, idx_r} < alu_rsp.res);
  assign old_bit = rd_row_r[idx_r[ROW_SEL_W-1:0]];
  assign new_bit = is_write ? wv_r : old_bit;

  // Next state
  always_comb begin
    state_nxt = state_r;
    if (cfg_wr) begin
      state_nxt = ST_CLEAR;
    end else begin
      case (state_r)
        ST_CLEAR: if (clr_row_r == '1) state_nxt = ST_IDLE;
        ST_IDLE: begin
          if (start && (in_action[ACT_INDEX_BIT] || crd_ok)) state_nxt = ST_MAC;
        end
        ST_MAC: begin
          if (mstep_r == MAC_LAST) begin
            if (!by_index)   state_nxt = ST_READ;
            else if (idx_ok) state_nxt = ST_DIV;
            else             state_nxt = ST_IDLE;
          end
        end
        ST_DIV: if (dcnt_r == '1 && axis_r == AXIS_Z) state_nxt = ST_READ;
        ST_READ: state_nxt = ST_MOD;
        ST_MOD:  state_nxt = ST_IDLE;
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  // Datapath and outputs
  always_comb begin
    clr_row_nxt   = clr_row_r;
    act_nxt       = act_r;
    wv_nxt        = wv_r;
    crd_x_nxt     = crd_x_r;
    crd_y_nxt     = crd_y_r;
    crd_z_nxt     = crd_z_r;
    crd_w_nxt     = crd_w_r;
    idx_nxt       = idx_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    mstep_nxt     = mstep_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    axis_nxt      = axis_r;
    wall_nxt      = wall_r;
    out_valid_nxt = 1'b0;
    out_val_nxt   = out_val_r;
    out_rng_nxt   = out_rng_r;
    out_idx_nxt   = out_idx_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_z_nxt     = out_z_r;
    out_w_nxt     = out_w_r;
    out_wall_nxt  = out_wall_r;
    mem_we        = 1'b0;
    mem_waddr     = clr_row_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;

    case (state_r)
      // zero one row per cycle
      ST_CLEAR: begin
        mem_we      = 1'b1;
        clr_row_nxt = clr_row_r + 1'b1;
      end

      // capture the item; coordinates outside the grid finish at once
      ST_IDLE: begin
        if (start) begin
          act_nxt   = in_action;
          wv_nxt    = in_write_value;
          crd_x_nxt = in_coord_x[CRD_W-1:0];
          crd_y_nxt = in_coord_y[CRD_W-1:0];
          crd_z_nxt = in_coord_z[CRD_W-1:0];
          crd_w_nxt = in_coord_w[CRD_W-1:0];
          idx_nxt   = in_cell_index[IDX_W-1:0];
          neg_nxt   = in_cell_index[CNT_W-1];
          mstep_nxt = '0;
          acc_nxt   = in_action[ACT_INDEX_BIT] ? CNT_W'(sw)
                                               : CNT_W'(in_coord_w[CRD_W-1:0]);
          if (!in_action[ACT_INDEX_BIT] && !crd_ok) begin
            out_valid_nxt = 1'b1;
            out_val_nxt   = 1'b1;
            out_rng_nxt   = 1'b0;
            out_idx_nxt   = '0;
            out_x_nxt     = '0;
            out_y_nxt     = '0;
            out_z_nxt     = '0;
            out_w_nxt     = '0;
            out_wall_nxt  = wall_r;
          end
        end
      end

      // linear index (coordinate access) or cell total (index access)
      ST_MAC: begin
        acc_nxt   = alu_rsp.res;
        mstep_nxt = mstep_r + 2'd1;
        if (mstep_r == MAC_LAST) begin
          if (!by_index) begin
            idx_nxt = alu_rsp.res[IDX_W-1:0];
          end else if (idx_ok) begin
            dvd_nxt  = idx_r;
            rem_nxt  = '0;
            dcnt_nxt = '0;
            axis_nxt = AXIS_X;
          end else begin
            out_valid_nxt = 1'b1;
            out_val_nxt   = 1'b0;
            out_rng_nxt   = 1'b0;
            out_idx_nxt   = '0;
            out_x_nxt     = '0;
            out_y_nxt     = '0;
            out_z_nxt     = '0;
            out_w_nxt     = '0;
            out_wall_nxt  = wall_r;
          end
        end
      end

      // split the index: remainder per axis, quotient carries on
      ST_DIV: begin
        dvd_nxt  = alu_rsp.res[IDX_W-1:0];
        rem_nxt  = alu_rsp.rem;
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == '1) begin
          rem_nxt  = '0;
          axis_nxt = axis_r + 2'd1;
          case (axis_r)
            AXIS_X: crd_x_nxt = alu_rsp.rem[CRD_W-1:0];
            AXIS_Y: crd_y_nxt = alu_rsp.rem[CRD_W-1:0];
            default: begin
              crd_z_nxt = alu_rsp.rem[CRD_W-1:0];
              crd_w_nxt = alu_rsp.res[CRD_W-1:0];
            end
          endcase
        end
      end

      ST_READ: mem_re = 1'b1;

      // read-modify-write of the row, count update, result
      ST_MOD: begin
        if (is_write && (wv_r != old_bit)) begin
          mem_we    = 1'b1;
          mem_waddr = idx_r[IDX_W-1:ROW_SEL_W];
          mem_wdata = rd_row_r;
          mem_wdata[idx_r[ROW_SEL_W-1:0]] = wv_r;
          wall_nxt  = wv_r ? (wall_r + CNT_W'(1)) : (wall_r - CNT_W'(1));
        end
        out_valid_nxt = 1'b1;
        out_val_nxt   = new_bit;
        out_rng_nxt   = 1'b1;
        out_idx_nxt   = idx_r;
        out_x_nxt     = crd_x_r;
        out_y_nxt     = crd_y_r;
        out_z_nxt     = crd_z_r;
        out_w_nxt     = crd_w_r;
        out_wall_nxt  = wall_nxt;
      end

      default: ;
    endcase

    // size write restarts the clear
    if (cfg_wr) begin
      clr_row_nxt = '0;
      wall_nxt    = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_row_r   <= '0;
      wall_r      <= '0;
      out_valid_r <= 1'b0;
      mstep_r     <= '0;
      dcnt_r      <= '0;
      axis_r      <= AXIS_X;
    end else begin
      state_r     <= state_nxt;
      clr_row_r   <= clr_row_nxt;
      wall_r      <= wall_nxt;
      out_valid_r <= out_valid_nxt;
      mstep_r     <= mstep_nxt;
      dcnt_r      <= dcnt_nxt;
      axis_r      <= axis_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    wv_r       <= wv_nxt;
    crd_x_r    <= crd_x_nxt;
    crd_y_r    <= crd_y_nxt;
    crd_z_r    <= crd_z_nxt;
    crd_w_r    <= crd_w_nxt;
    idx_r      <= idx_nxt;
    neg_r      <= neg_nxt;
    acc_r      <= acc_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    out_val_r  <= out_val_nxt;
    out_rng_r  <= out_rng_nxt;
    out_idx_r  <= out_idx_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_z_r    <= out_z_nxt;
    out_w_r    <= out_w_nxt;
    out_wall_r <= out_wall_nxt;
  end

  // Cell bit memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) cell_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_row_r <= cell_mem[idx_r[IDX_W-1:ROW_SEL_W]];
  end

  assign out_valid        = out_valid_r;
  assign out_cell_value   = out_val_r;
  assign out_in_range     = out_rng_r;
  assign out_linear_index = out_idx_r;
  assign out_out_x        = out_x_r;
  assign out_out_y        = out_y_r;
  assign out_out_z        = out_z_r;
  assign out_out_w        = out_w_r;
  assign out_wall_count   = out_wall_r;

  // An accepted item either finishes next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || out_valid))
    else $error("accepted item neither busy nor finished");

  // Partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < axis_size))
    else $error("divide remainder out of bound");

  // Wall count moves by at most one per cycle between size writes
  a_wall_step: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_wr |=> (wall_r == $past(wall_r) || wall_r == $past(wall_r) + CNT_W'(1) ||
                 wall_r + CNT_W'(1) == $past(wall_r)))
    else $error("wall count jumped");

  // Wall count never exceeds the store size
  a_wall_max: assert property (@(posedge clk) disable iff (!rst_n)
    wall_r <= CNT_W'(MAX_CELLS))
    else $error("wall count above capacity");

  // Results outside the grid carry zero index and coordinates
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_range) |-> (out_linear_index == '0 && out_out_x == '0 &&
                                      out_out_y == '0 && out_out_z == '0 &&
                                      out_out_w == '0))
    else $error("out-of-range result has nonzero address");

endmodule
